>>> rtl/apu_pkg.sv
`default_nettype none
package apu_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int FRAC_BITS_DEF = 24;

	// Configuration port geometry.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEARNING_RATE = 2'd0,
		CFG_BETA_FIRST    = 2'd1,
		CFG_BETA_SECOND   = 2'd2,
		CFG_ELEMENT_COUNT = 2'd3
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam logic [15:0] RST_LEARNING_RATE = 16'd10;
	localparam logic [15:0] RST_BETA_FIRST = 16'd58982;
	localparam logic [15:0] RST_BETA_SECOND = 16'd65470;
	localparam logic [10:0] RST_ELEMENT_COUNT = 11'd1024;

	// Limits of the 32-bit signed result.
	localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] INT32_MIN = 32'h8000_0000;

	// Configuration register contents.
	typedef struct packed {
		logic [15:0] lr;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [10:0] count;
	} apu_cfg_t;

	// One item after the moment update.
	typedef struct packed {
		logic signed [31:0] p;
		logic signed [31:0] m;
		logic [31:0]        u;
		logic [16:0]        bp;
		logic               last;
	} apu_upd_t;

	// Data that travels beside the divider.
	typedef struct packed {
		logic signed [31:0] p;
		logic               q_neg;
		logic               num_neg;
		logic               den_zero;
		logic               last;
	} apu_side_t;

endpackage
`default_nettype wire

>>> rtl/apu_state.sv
`default_nettype none
module apu_state #(
	parameter int MAX_ELEMENTS = apu_pkg::MAX_ELEMENTS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  apu_pkg::apu_cfg_t      cfg,
	input  wire                    bp_load,
	input  wire  [15:0]            bp_load_val,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire  signed [31:0]     param_value,
	input  wire  signed [31:0]     gradient,
	output logic                   out_valid,
	input  wire                    out_ready,
	output apu_pkg::apu_upd_t      out_upd
);

	localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int FILL_W = $clog2(MAX_ELEMENTS + 1);
	localparam int CNT_W = (FILL_W > 11) ? FILL_W : 11;

	// Moment stores.
	logic signed [31:0] m_mem [MAX_ELEMENTS];
	logic [31:0]        u_mem [MAX_ELEMENTS];

	logic [IDX_W-1:0]  idx_q;
	logic [FILL_W-1:0] fill_q;
	logic [16:0]       bp_q;

	logic               v1_q, v2_q;
	logic signed [31:0] p_s1, g_s1, rm_s1, fm_s1;
	logic [31:0]        ru_s1, fu_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [16:0]        bp_s1;
	logic               last_s1, fwd_s1, zero_s1;
	apu_pkg::apu_upd_t  upd_s2;

	logic              rdy1, rdy2, accept, adv1, last, fwd_hit;
	logic [CNT_W-1:0]  cnt_eff;
	logic [CNT_W:0]    idx_p1;
	logic [32:0]       bp_prod;

	logic signed [31:0] m_old, m_new;
	logic [31:0]        u_old, u_new, absg, bu_sh;
	logic signed [48:0] prod_a, prod_b;
	logic signed [49:0] m_sum;
	logic [47:0]        bu;

	// Handshake through the two stages.
	assign rdy2 = !v2_q || out_ready;
	assign rdy1 = !v1_q || rdy2;
	assign in_stall = !rdy1;
	assign accept = in_valid && rdy1;
	assign adv1 = v1_q && rdy2;

	// Effective pass length and end-of-pass detection.
	always_comb begin
		cnt_eff = CNT_W'(cfg.count);
		if (cnt_eff == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (cnt_eff > CNT_W'(MAX_ELEMENTS)) begin
			cnt_eff = CNT_W'(MAX_ELEMENTS);
		end
		idx_p1 = (CNT_W + 1)'(idx_q) + 1'b1;
		last = idx_p1 >= {1'b0, cnt_eff};
	end

	assign bp_prod = bp_q * cfg.b1;
	assign fwd_hit = adv1 && (idx_s1 == idx_q);

	// Index, fill count and running beta power.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			fill_q <= '0;
			bp_q <= {1'b0, apu_pkg::RST_BETA_FIRST};
		end else begin
			if (accept) begin
				idx_q <= last ? '0 : idx_q + 1'b1;
				if (FILL_W'(idx_q) == fill_q) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (bp_load) begin
				bp_q <= {1'b0, bp_load_val};
			end else if (accept && last) begin
				bp_q <= bp_prod[32:16];
			end
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= in_valid;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
		end
	end

	// Store read at accept, with the entry state and forwarding decided here.
	always_ff @(posedge clk) begin
		if (accept) begin
			rm_s1 <= m_mem[idx_q];
			ru_s1 <= u_mem[idx_q];
			p_s1 <= param_value;
			g_s1 <= gradient;
			idx_s1 <= idx_q;
			bp_s1 <= bp_q;
			last_s1 <= last;
			zero_s1 <= !(FILL_W'(idx_q) < fill_q);
			fwd_s1 <= fwd_hit;
			fm_s1 <= m_new;
			fu_s1 <= u_new;
		end
	end

	// Moment and infinity-norm update.
	always_comb begin
		m_old = fwd_s1 ? fm_s1 : (zero_s1 ? '0 : rm_s1);
		u_old = fwd_s1 ? fu_s1 : (zero_s1 ? '0 : ru_s1);
		prod_a = $signed({1'b0, cfg.b1}) * m_old;
		prod_b = $signed(18'h10000 - {2'b0, cfg.b1}) * g_s1;
		m_sum = 50'(prod_a) + 50'(prod_b);
		m_new = m_sum[47:16];
		bu = cfg.b2 * u_old;
		bu_sh = bu[47:16];
		absg = g_s1[31] ? 32'(-g_s1) : 32'(g_s1);
		u_new = (absg > bu_sh) ? absg : bu_sh;
	end

	// Write back and hand on.
	always_ff @(posedge clk) begin
		if (adv1) begin
			m_mem[idx_s1] <= m_new;
			u_mem[idx_s1] <= u_new;
			upd_s2.p <= p_s1;
			upd_s2.m <= m_new;
			upd_s2.u <= u_new;
			upd_s2.bp <= bp_s1;
			upd_s2.last <= last_s1;
		end
	end

	assign out_valid = v2_q;
	assign out_upd = upd_s2;

endmodule
`default_nettype wire

>>> rtl/apu_div.sv
`default_nettype none
module apu_div #(
	parameter int NUM_W = 53,
	parameter int DEN_W = 35
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire  [NUM_W-1:0]       num_mag,
	input  wire  [DEN_W-1:0]       den_mag,
	input  apu_pkg::apu_side_t     in_side,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [NUM_W-1:0]       quo,
	output apu_pkg::apu_side_t     out_side
);

	// One quotient bit per stage, restoring.
	logic               v_q    [NUM_W];
	logic [DEN_W-1:0]   rem_q  [NUM_W];
	logic [NUM_W-1:0]   acc_q  [NUM_W];
	logic [DEN_W-1:0]   dv_q   [NUM_W];
	apu_pkg::apu_side_t side_q [NUM_W];
	logic               rdy    [NUM_W+1];

	assign rdy[NUM_W] = out_ready;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic               v_i;
		logic [DEN_W-1:0]   rem_i, dv_i;
		logic [NUM_W-1:0]   acc_i;
		apu_pkg::apu_side_t side_i;
		logic [DEN_W:0]     trial, diff;
		logic               ge;

		if (k == 0) begin : g_first
			assign v_i = in_valid;
			assign rem_i = '0;
			assign dv_i = den_mag;
			assign acc_i = num_mag;
			assign side_i = in_side;
		end else begin : g_next
			assign v_i = v_q[k-1];
			assign rem_i = rem_q[k-1];
			assign dv_i = dv_q[k-1];
			assign acc_i = acc_q[k-1];
			assign side_i = side_q[k-1];
		end

		assign trial = {rem_i, acc_i[NUM_W-1]};
		assign diff = trial - {1'b0, dv_i};
		assign ge = trial >= {1'b0, dv_i};
		assign rdy[k] = !v_q[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_i) begin
				rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				acc_q[k] <= {acc_i[NUM_W-2:0], ge};
				dv_q[k] <= dv_i;
				side_q[k] <= side_i;
			end
		end
	end

	assign in_ready = rdy[0];
	assign out_valid = v_q[NUM_W-1];
	assign quo = acc_q[NUM_W-1];
	assign out_side = side_q[NUM_W-1];

endmodule
`default_nettype wire

>>> rtl/adamax_parameter_update_unit.sv
`default_nettype none
// AdaMax update engine: each item carries one parameter and its gradient, and one
// updated parameter comes back per item, in order. The first-moment and infinity-norm
// stores are synchronous memories with a separate read and write port, indexed by an
// internal element counter; a fill count makes never-written entries read as zero, so
// there is no clearing pass after reset. One item is accepted per clock while in_stall
// is low. The restoring divider resolves one quotient bit per stage for a quotient of
// NUM_W = 49 + max(FRAC_BITS - 20, 0) bits (53 at the defaults). Back-to-back items
// on the same entry are served by forwarding around the memory. The user must write
// configuration only while no item is in flight; the block itself does not enforce
// this. Writing beta_first also restarts the bias-correction power.
module adamax_parameter_update_unit #(
	parameter int MAX_ELEMENTS = apu_pkg::MAX_ELEMENTS_DEF,
	parameter int FRAC_BITS = apu_pkg::FRAC_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [apu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [apu_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  signed [31:0]                param_value,
	input  wire  signed [31:0]                gradient,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic signed [31:0]                new_value,
	output logic                              saturated,
	output logic                              pass_end
);

	localparam int NUM_SH = (FRAC_BITS > 20) ? FRAC_BITS - 20 : 0;
	localparam int DEN_SH = (FRAC_BITS < 20) ? 20 - FRAC_BITS : 0;
	localparam int NUM_W = 49 + NUM_SH;
	localparam int DEN_W = 35 + DEN_SH;
	localparam longint EPS_FIX = ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;

	apu_pkg::apu_cfg_t cfg_q;
	logic              bp_load;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lr <= apu_pkg::RST_LEARNING_RATE;
			cfg_q.b1 <= apu_pkg::RST_BETA_FIRST;
			cfg_q.b2 <= apu_pkg::RST_BETA_SECOND;
			cfg_q.count <= apu_pkg::RST_ELEMENT_COUNT;
		end else if (cfg_we) begin
			unique case (apu_pkg::cfg_reg_t'(cfg_index))
				apu_pkg::CFG_LEARNING_RATE: cfg_q.lr <= cfg_data;
				apu_pkg::CFG_BETA_FIRST:    cfg_q.b1 <= cfg_data;
				apu_pkg::CFG_BETA_SECOND:   cfg_q.b2 <= cfg_data;
				apu_pkg::CFG_ELEMENT_COUNT: cfg_q.count <= 11'(cfg_data);
				default: ;
			endcase
		end
	end

	assign bp_load = cfg_we && (apu_pkg::cfg_reg_t'(cfg_index) == apu_pkg::CFG_BETA_FIRST);

	// Memory read-modify-write front end.
	logic              st_valid, st_ready;
	apu_pkg::apu_upd_t st_upd;

	apu_state #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_state (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.bp_load(bp_load),
		.bp_load_val(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.param_value(param_value),
		.gradient(gradient),
		.out_valid(st_valid),
		.out_ready(st_ready),
		.out_upd(st_upd)
	);

	// Stage 3: denominator and numerator products.
	logic               v3_q, v4_q, rdy3, rdy4;
	logic signed [50:0] den_prod_s3;
	logic signed [48:0] num_prod_s3;
	logic signed [31:0] p_s3;
	logic               last_s3;

	assign rdy3 = !v3_q || rdy4;
	assign st_ready = rdy3;

	always_ff @(posedge clk) begin
		if (rdy3 && st_valid) begin
			den_prod_s3 <= ($signed({1'b0, st_upd.bp}) - 18'sd65536) * $signed({1'b0, st_upd.u});
			num_prod_s3 <= $signed({1'b0, cfg_q.lr}) * st_upd.m;
			p_s3 <= st_upd.p;
			last_s3 <= st_upd.last;
		end
	end

	// Stage 4: scale, add epsilon, split into sign and magnitude.
	logic signed [34:0]      den_base;
	logic signed [DEN_W-1:0] den_full;
	logic signed [NUM_W-1:0] num_full;
	logic [NUM_W-1:0]        nmag_s4;
	logic [DEN_W-1:0]        dmag_s4;
	apu_pkg::apu_side_t      side_s4;
	logic                    div_ready;

	always_comb begin
		den_base = 35'(den_prod_s3 >>> 16) + 35'(EPS_FIX);
		den_full = DEN_W'(den_base) <<< DEN_SH;
		num_full = NUM_W'(num_prod_s3) <<< NUM_SH;
	end

	assign rdy4 = !v4_q || div_ready;

	always_ff @(posedge clk) begin
		if (rdy4 && v3_q) begin
			nmag_s4 <= num_full[NUM_W-1] ? NUM_W'(-num_full) : NUM_W'(num_full);
			dmag_s4 <= den_full[DEN_W-1] ? DEN_W'(-den_full) : DEN_W'(den_full);
			side_s4.p <= p_s3;
			side_s4.q_neg <= num_full[NUM_W-1] ^ den_full[DEN_W-1];
			side_s4.num_neg <= num_full[NUM_W-1];
			side_s4.den_zero <= (den_full == '0);
			side_s4.last <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (rdy3) begin
				v3_q <= st_valid;
			end
			if (rdy4) begin
				v4_q <= v3_q;
			end
		end
	end

	// Quotient of magnitudes.
	logic               dv_valid, rdy_o;
	logic [NUM_W-1:0]   quo;
	apu_pkg::apu_side_t dv_side;

	apu_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v4_q),
		.in_ready(div_ready),
		.num_mag(nmag_s4),
		.den_mag(dmag_s4),
		.in_side(side_s4),
		.out_valid(dv_valid),
		.out_ready(rdy_o),
		.quo(quo),
		.out_side(dv_side)
	);

	// Sign, add to the parameter, saturate.
	logic signed [NUM_W:0]   q_signed;
	logic signed [NUM_W+1:0] sum;
	logic [NUM_W+1-31:0]     sum_hi;
	logic [31:0]             res;
	logic                    res_sat;

	always_comb begin
		q_signed = dv_side.q_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		sum = (NUM_W + 2)'(dv_side.p) + (NUM_W + 2)'(q_signed);
		sum_hi = sum[NUM_W+1:31];
		res = sum[31:0];
		res_sat = 1'b0;
		if (dv_side.den_zero) begin
			res_sat = 1'b1;
			res = dv_side.num_neg ? apu_pkg::INT32_MIN : apu_pkg::INT32_MAX;
		end else if (!((&sum_hi) || !(|sum_hi))) begin
			res_sat = 1'b1;
			res = sum[NUM_W+1] ? apu_pkg::INT32_MIN : apu_pkg::INT32_MAX;
		end
	end

	// Output register.
	logic        out_valid_q, sat_q, last_q;
	logic [31:0] value_q;

	assign rdy_o = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_o) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && dv_valid) begin
			value_q <= res;
			sat_q <= res_sat;
			last_q <= dv_side.last;
		end
	end

	assign out_valid = out_valid_q;
	assign new_value = value_q;
	assign saturated = sat_q;
	assign pass_end = last_q;

endmodule
`default_nettype wire

>>> rtl/apu_checker.sv
`default_nettype none
module apu_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_stall,
	input wire signed [31:0] param_value,
	input wire signed [31:0] gradient,
	input wire               out_valid,
	input wire               out_stall,
	input wire signed [31:0] new_value,
	input wire               saturated,
	input wire               pass_end
);

	// A stalled input item stays offered unchanged.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(param_value) && $stable(gradient))
		else $error("input item changed while stalled");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	// A stalled result keeps its contents.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(new_value) && $stable(saturated) && $stable(pass_end))
		else $error("result item changed while stalled");

	// A saturated result sits at one of the two limits.
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (new_value == 32'sh7FFF_FFFF) || (new_value == 32'sh8000_0000))
		else $error("saturated item not at a limit");

	// Leaving reset, the block is empty and takes input.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("block not empty after reset");

endmodule

bind adamax_parameter_update_unit apu_checker u_apu_checker (.*);
`default_nettype wire
